@@ rtl/core/ebalu_pkg.sv @@
// Shared types and constants for the 8-bit ALU with decimal mode.
// Used by every module in rtl/core; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ebalu_pkg;

  typedef enum logic [3:0] {
    OP_ADC = 4'd0,
    OP_SBC = 4'd1,
    OP_AND = 4'd2,
    OP_ORA = 4'd3,
    OP_EOR = 4'd4,
    OP_BIT = 4'd5,
    OP_CMP = 4'd6,
    OP_INC = 4'd7,
    OP_DEC = 4'd8,
    OP_ANC = 4'd9,
    OP_ARR = 4'd10,
    OP_AXS = 4'd11
  } op_t;

  // status bit positions
  localparam int unsigned FLAG_C = 0;
  localparam int unsigned FLAG_Z = 1;
  localparam int unsigned FLAG_D = 3;
  localparam int unsigned FLAG_V = 6;
  localparam int unsigned FLAG_N = 7;

  // decimal adjust constants (per digit)
  localparam logic [4:0] DIGIT_MAX = 5'd9;
  localparam logic [3:0] DIGIT_ADJ = 4'd6;
  localparam logic [4:0] ARR_LIMIT = 5'd5;

  typedef struct packed {
    logic [3:0] op;
    logic [7:0] a;
    logic [7:0] x;
    logic [7:0] r;
    logic [7:0] m;
    logic [7:0] p;
  } in_t;

  typedef struct packed {
    logic [3:0] op;
    logic [7:0] a;
    logic [7:0] x;
    logic [7:0] r;
    logic [7:0] m;
    logic [7:0] p;
    logic [8:0] bin_sum;
    logic [8:0] sub;
    logic [4:0] adc_lo;
    logic [4:0] adc_hi;
    logic [4:0] sbc_lo;
    logic [8:0] cmp;
    logic [7:0] inc;
    logic [7:0] dec;
    logic [8:0] axs;
    logic [7:0] and_am;
    logic [7:0] or_am;
    logic [7:0] eor_am;
  } s1_t;

  typedef struct packed {
    logic [3:0] op;
    logic [7:0] a;
    logic [7:0] x;
    logic [7:0] r;
    logic [7:0] m;
    logic [7:0] p;
    logic [8:0] bin_sum;
    logic [8:0] sub;
    logic [8:0] cmp;
    logic [7:0] inc;
    logic [7:0] dec;
    logic [8:0] axs;
    logic [7:0] and_am;
    logic [7:0] or_am;
    logic [7:0] eor_am;
    logic [7:0] adc_dec_res;
    logic       adc_dec_c;
    logic       adc_dec_n;
    logic       adc_dec_v;
    logic [7:0] sbc_dec_res;
    logic [7:0] arr_bin;
    logic [7:0] arr_dec_res;
    logic       arr_dec_c;
  } s2_t;

  typedef struct packed {
    logic [7:0] acc;
    logic [7:0] x;
    logic [7:0] r;
    logic [7:0] status;
  } out_t;

endpackage

`default_nettype wire

@@ rtl/core/eight_bit_alu_with_bcd.sv @@
// An accepted item passes the sum, adjust and flags stage registers in turn to the output.
// Throughput: one item per cycle; each of the three register stages stalls
// only while the stage after it is full and not taken.
// Reset (rst, synchronous) clears the stage valid bits; data registers keep.
// Top level of the 8-bit ALU with decimal mode; depends on ebalu_pkg,
// ebalu_sum, ebalu_adjust and ebalu_flags.
`timescale 1ns / 1ps
`default_nettype none

module eight_bit_alu_with_bcd (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,  // acc_in, x_in, reg_in, data_in, status_in
  input  wire logic [3:0]  s_tuser,  // req_type
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata   // acc_out, x_out, reg_out, status_out
);

  ebalu_pkg::in_t  in_data;
  ebalu_pkg::s1_t  s1_data;
  ebalu_pkg::s2_t  s2_data;
  ebalu_pkg::out_t res;
  logic            s1_valid;
  logic            s1_ready;
  logic            s2_valid;
  logic            s2_ready;

  always_comb begin
    in_data.op = s_tuser;
    in_data.a  = s_tdata[7:0];
    in_data.x  = s_tdata[15:8];
    in_data.r  = s_tdata[23:16];
    in_data.m  = s_tdata[31:24];
    in_data.p  = s_tdata[39:32];
  end

  ebalu_sum u_sum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (in_data),
    .out_valid (s1_valid),
    .out_ready (s1_ready),
    .out_data  (s1_data)
  );

  ebalu_adjust u_adjust (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .in_data   (s1_data),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .out_data  (s2_data)
  );

  ebalu_flags u_flags (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_valid),
    .in_ready  (s2_ready),
    .in_data   (s2_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (res)
  );

  assign m_tdata = {res.status, res.r, res.x, res.acc};

  a_empty_accepts: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("pipeline refused an item with the output empty");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

  a_fill_latency: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !s1_valid && !s2_valid && !m_tvalid) |=> ##1 s2_valid)
    else $error("item lost between first and second stage");

endmodule

`default_nettype wire

@@ rtl/core/ebalu_sum.sv @@
// Stage 1: binary adds, subtracts and logic ops on the incoming item.
// Depends on ebalu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ebalu_sum (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire ebalu_pkg::in_t in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output ebalu_pkg::s1_t     out_data
);

  ebalu_pkg::s1_t d;
  logic           cin;
  logic           borrow;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    cin      = in_data.p[ebalu_pkg::FLAG_C];
    borrow   = ~cin;
    d.op     = in_data.op;
    d.a      = in_data.a;
    d.x      = in_data.x;
    d.r      = in_data.r;
    d.m      = in_data.m;
    d.p      = in_data.p;
    d.bin_sum = {1'b0, in_data.a} + {1'b0, in_data.m} + {8'd0, cin};
    d.sub    = {1'b0, in_data.a} - {1'b0, in_data.m} - {8'd0, borrow};
    d.adc_lo = {1'b0, in_data.a[3:0]} + {1'b0, in_data.m[3:0]} + {4'd0, cin};
    d.adc_hi = {1'b0, in_data.a[7:4]} + {1'b0, in_data.m[7:4]};
    d.sbc_lo = {1'b0, in_data.a[3:0]} - {1'b0, in_data.m[3:0]} - {4'd0, borrow};
    d.cmp    = {1'b0, in_data.r} - {1'b0, in_data.m};
    d.inc    = in_data.r + 8'd1;
    d.dec    = in_data.r - 8'd1;
    d.axs    = {1'b0, in_data.a & in_data.x} - {1'b0, in_data.m};
    d.and_am = in_data.a & in_data.m;
    d.or_am  = in_data.a | in_data.m;
    d.eor_am = in_data.a ^ in_data.m;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/ebalu_adjust.sv @@
// Stage 2: decimal digit adjust for adc, sbc and arr.
// Depends on ebalu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ebalu_adjust (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire ebalu_pkg::s1_t in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output ebalu_pkg::s2_t     out_data
);

  ebalu_pkg::s2_t d;
  logic           lo_gt9;
  logic [3:0]     lo_adj;
  logic [4:0]     hi1;
  logic [5:0]     hi2;
  logic           lneg;
  logic [3:0]     sbc_lo_f;
  logic [4:0]     sbc_hi;
  logic [3:0]     sbc_hi_f;
  logic [7:0]     t;
  logic           arr_lo_fix;
  logic           arr_c;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    // adc decimal
    lo_gt9 = in_data.adc_lo > ebalu_pkg::DIGIT_MAX;
    lo_adj = in_data.adc_lo[3:0] + (lo_gt9 ? ebalu_pkg::DIGIT_ADJ : 4'd0);
    hi1    = in_data.adc_hi + {4'd0, lo_gt9};
    hi2    = {1'b0, hi1} + ((hi1 > ebalu_pkg::DIGIT_MAX) ? {2'd0, ebalu_pkg::DIGIT_ADJ} : 6'd0);
    // sbc decimal
    lneg     = in_data.sbc_lo[4];
    sbc_lo_f = in_data.sbc_lo[3:0] - (lneg ? ebalu_pkg::DIGIT_ADJ : 4'd0);
    sbc_hi   = {1'b0, in_data.a[7:4]} - {1'b0, in_data.m[7:4]} - {4'd0, lneg};
    sbc_hi_f = sbc_hi[3:0] - (sbc_hi[4] ? ebalu_pkg::DIGIT_ADJ : 4'd0);
    // arr
    t          = in_data.and_am;
    arr_lo_fix = ({1'b0, t[3:0]} + {4'd0, t[0]}) > ebalu_pkg::ARR_LIMIT;
    arr_c      = ({1'b0, t[7:4]} + {4'd0, t[4]}) > ebalu_pkg::ARR_LIMIT;

    d.op      = in_data.op;
    d.a       = in_data.a;
    d.x       = in_data.x;
    d.r       = in_data.r;
    d.m       = in_data.m;
    d.p       = in_data.p;
    d.bin_sum = in_data.bin_sum;
    d.sub     = in_data.sub;
    d.cmp     = in_data.cmp;
    d.inc     = in_data.inc;
    d.dec     = in_data.dec;
    d.axs     = in_data.axs;
    d.and_am  = in_data.and_am;
    d.or_am   = in_data.or_am;
    d.eor_am  = in_data.eor_am;
    d.adc_dec_res = {hi2[3:0], lo_adj};
    d.adc_dec_c   = hi2[5:4] != 2'd0;
    d.adc_dec_n   = hi1[3];
    d.adc_dec_v   = ~(in_data.a[7] ^ in_data.m[7]) & (in_data.a[7] ^ hi1[3]);
    d.sbc_dec_res = {sbc_hi_f, sbc_lo_f};
    d.arr_bin     = {in_data.p[ebalu_pkg::FLAG_C], t[7:1]};
    d.arr_dec_res[3:0] = t[4:1] + (arr_lo_fix ? ebalu_pkg::DIGIT_ADJ : 4'd0);
    d.arr_dec_res[7:4] = {in_data.p[ebalu_pkg::FLAG_C], t[7:5]}
                         + (arr_c ? ebalu_pkg::DIGIT_ADJ : 4'd0);
    d.arr_dec_c   = arr_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/ebalu_flags.sv @@
// Stage 3: result select per operation and status byte update.
// Holds the output register. Depends on ebalu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ebalu_flags (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire ebalu_pkg::s2_t in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output ebalu_pkg::out_t    out_data
);

  ebalu_pkg::out_t d;
  logic [7:0]      st;
  logic [7:0]      nz_val;
  logic            nz_en;
  logic            dmode;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    dmode  = in_data.p[ebalu_pkg::FLAG_D];
    st     = in_data.p;
    d.acc  = in_data.a;
    d.x    = in_data.x;
    d.r    = in_data.r;
    nz_val = 8'd0;
    nz_en  = 1'b0;
    unique case (ebalu_pkg::op_t'(in_data.op))
      ebalu_pkg::OP_ADC: begin
        if (!dmode) begin
          d.acc = in_data.bin_sum[7:0];
          st[ebalu_pkg::FLAG_V] = ~(in_data.a[7] ^ in_data.m[7])
                                  & (in_data.a[7] ^ in_data.bin_sum[7]);
          st[ebalu_pkg::FLAG_C] = in_data.bin_sum[8];
          nz_val = in_data.bin_sum[7:0];
          nz_en  = 1'b1;
        end else begin
          d.acc = in_data.adc_dec_res;
          st[ebalu_pkg::FLAG_Z] = in_data.bin_sum[7:0] == 8'd0;
          st[ebalu_pkg::FLAG_N] = in_data.adc_dec_n;
          st[ebalu_pkg::FLAG_V] = in_data.adc_dec_v;
          st[ebalu_pkg::FLAG_C] = in_data.adc_dec_c;
        end
      end
      ebalu_pkg::OP_SBC: begin
        d.acc = dmode ? in_data.sbc_dec_res : in_data.sub[7:0];
        st[ebalu_pkg::FLAG_V] = (in_data.a[7] ^ in_data.m[7])
                                & (in_data.a[7] ^ in_data.sub[7]);
        st[ebalu_pkg::FLAG_C] = ~in_data.sub[8];
        nz_val = in_data.sub[7:0];
        nz_en  = 1'b1;
      end
      ebalu_pkg::OP_AND: begin
        d.acc  = in_data.and_am;
        nz_val = in_data.and_am;
        nz_en  = 1'b1;
      end
      ebalu_pkg::OP_ORA: begin
        d.acc  = in_data.or_am;
        nz_val = in_data.or_am;
        nz_en  = 1'b1;
      end
      ebalu_pkg::OP_EOR: begin
        d.acc  = in_data.eor_am;
        nz_val = in_data.eor_am;
        nz_en  = 1'b1;
      end
      ebalu_pkg::OP_BIT: begin
        st[ebalu_pkg::FLAG_V] = in_data.m[6];
        st[ebalu_pkg::FLAG_N] = in_data.m[7];
        st[ebalu_pkg::FLAG_Z] = in_data.and_am == 8'd0;
      end
      ebalu_pkg::OP_CMP: begin
        st[ebalu_pkg::FLAG_C] = ~in_data.cmp[8];
        nz_val = in_data.cmp[7:0];
        nz_en  = 1'b1;
      end
      ebalu_pkg::OP_INC: begin
        d.r    = in_data.inc;
        nz_val = in_data.inc;
        nz_en  = 1'b1;
      end
      ebalu_pkg::OP_DEC: begin
        d.r    = in_data.dec;
        nz_val = in_data.dec;
        nz_en  = 1'b1;
      end
      ebalu_pkg::OP_ANC: begin
        d.acc  = in_data.and_am;
        st[ebalu_pkg::FLAG_C] = in_data.and_am[7];
        nz_val = in_data.and_am;
        nz_en  = 1'b1;
      end
      ebalu_pkg::OP_ARR: begin
        // N and Z come from the shifted value, before any decimal fix
        st[ebalu_pkg::FLAG_V] = in_data.arr_bin[6] ^ in_data.arr_bin[5];
        nz_val = in_data.arr_bin;
        nz_en  = 1'b1;
        if (!dmode) begin
          d.acc = in_data.arr_bin;
          st[ebalu_pkg::FLAG_C] = in_data.arr_bin[6];
        end else begin
          d.acc = in_data.arr_dec_res;
          st[ebalu_pkg::FLAG_C] = in_data.arr_dec_c;
        end
      end
      ebalu_pkg::OP_AXS: begin
        d.x    = in_data.axs[7:0];
        st[ebalu_pkg::FLAG_C] = ~in_data.axs[8];
        nz_val = in_data.axs[7:0];
        nz_en  = 1'b1;
      end
      default: begin
      end
    endcase
    if (nz_en) begin
      st[ebalu_pkg::FLAG_Z] = nz_val == 8'd0;
      st[ebalu_pkg::FLAG_N] = nz_val[7];
    end
    d.status = st;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= d;
    end
  end

  a_x_kept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_data.op != ebalu_pkg::OP_AXS)
    |=> (out_data.x == $past(in_data.x)))
    else $error("x changed by an op other than axs");

  a_status_pass: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (out_data.status[5:2] == $past(in_data.p[5:2])))
    else $error("status bits I, D, B or R changed");

  a_reg_kept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_data.op != ebalu_pkg::OP_INC
     && in_data.op != ebalu_pkg::OP_DEC)
    |=> (out_data.r == $past(in_data.r)))
    else $error("reg changed by an op other than inc or dec");

endmodule

`default_nettype wire

@@ tb/tb_eight_bit_alu_with_bcd.sv @@
// Testbench for eight_bit_alu_with_bcd: streams ALU requests through the
// item handshake and checks each result against an in-bench prediction.
// Depends on ebalu_pkg and the eight_bit_alu_with_bcd RTL.
`timescale 1ns / 1ps

module tb_eight_bit_alu_with_bcd;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_ITEMS = 1500;
  localparam int unsigned DRAIN_POINT = 700;
  localparam int unsigned TAIL_CYCLES = 12;
  localparam logic [3:0] OP_SPARE_LO = 4'd12;
  localparam logic [3:0] OP_SPARE_HI = 4'd15;

  typedef struct {
    logic [3:0] op;
    logic [7:0] a;
    logic [7:0] x;
    logic [7:0] r;
    logic [7:0] m;
    logic [7:0] p;
  } alu_req_t;

  typedef struct {
    logic [7:0] acc;
    logic [7:0] x;
    logic [7:0] r;
    logic [7:0] status;
  } alu_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;  // acc_in, x_in, reg_in, data_in, status_in
  logic [3:0]  s_tuser = '0;  // req_type
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;       // acc_out, x_out, reg_out, status_out

  alu_req_t    pending_reqs[$];
  alu_result_t expected_results[$];

  int unsigned error_count = 0;
  int unsigned results_checked = 0;
  int unsigned items_accepted = 0;
  int unsigned decimal_items = 0;
  int unsigned op_hits[16];
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned stall_phase = 0;
  int unsigned stall_mode = 0;

  eight_bit_alu_with_bcd dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #4 clk = ~clk;

  function automatic logic [7:0] put_nz(logic [7:0] p, logic [7:0] v);
    logic [7:0] q;
    q = p;
    q[ebalu_pkg::FLAG_Z] = (v == 8'h00);
    q[ebalu_pkg::FLAG_N] = v[7];
    return q;
  endfunction

  function automatic alu_result_t alu_predict(alu_req_t q);
    alu_result_t o;
    logic [7:0]  a, x, r, m, p, res, t8;
    logic [8:0]  wide;
    logic        cin, borrow, lneg, dm, c;
    int          lo, hi;
    a = q.a;
    x = q.x;
    r = q.r;
    m = q.m;
    p = q.p;
    cin = p[ebalu_pkg::FLAG_C];
    borrow = ~cin;
    dm = p[ebalu_pkg::FLAG_D];
    case (q.op)
      ebalu_pkg::OP_ADC: begin
        if (!dm) begin
          wide = {1'b0, a} + {1'b0, m} + {8'h00, cin};
          res = wide[7:0];
          p[ebalu_pkg::FLAG_V] = ~(a[7] ^ m[7]) & (a[7] ^ res[7]);
          p[ebalu_pkg::FLAG_C] = wide[8];
          p = put_nz(p, res);
          a = res;
        end else begin
          lo = int'(a[3:0]) + int'(m[3:0]) + int'(cin);
          hi = int'(a & 8'hF0) + int'(m & 8'hF0);
          p[ebalu_pkg::FLAG_Z] = (((lo + hi) & 'hFF) == 0);
          if (lo > 'h09) begin
            hi += 'h10;
            lo += 'h06;
          end
          p[ebalu_pkg::FLAG_N] = (hi & 'h80) != 0;
          p[ebalu_pkg::FLAG_V] = ((~(int'(a) ^ int'(m))) & (int'(a) ^ hi) & 'h80) != 0;
          if (hi > 'h90) hi += 'h60;
          p[ebalu_pkg::FLAG_C] = hi > 'hFF;
          a = 8'((lo & 'h0F) | (hi & 'hF0));
        end
      end
      ebalu_pkg::OP_SBC: begin
        wide = {1'b0, a} - {1'b0, m} - {8'h00, borrow};
        res = wide[7:0];
        p[ebalu_pkg::FLAG_V] = (a[7] ^ m[7]) & (a[7] ^ res[7]);
        p = put_nz(p, res);
        p[ebalu_pkg::FLAG_C] = ~wide[8];
        if (dm) begin
          lo = (int'(a[3:0]) - int'(m[3:0]) - int'(borrow)) & 'hFF;
          lneg = (lo & 'h80) != 0;
          if (lneg) lo = (lo - 6) & 'hFF;
          hi = (int'(a[7:4]) - int'(m[7:4]) - int'(lneg)) & 'hFF;
          if (hi & 'h80) hi = (hi - 6) & 'hFF;
          res = 8'(((hi << 4) & 'hF0) | (lo & 'h0F));
        end
        a = res;
      end
      ebalu_pkg::OP_AND: begin
        a = a & m;
        p = put_nz(p, a);
      end
      ebalu_pkg::OP_ORA: begin
        a = a | m;
        p = put_nz(p, a);
      end
      ebalu_pkg::OP_EOR: begin
        a = a ^ m;
        p = put_nz(p, a);
      end
      ebalu_pkg::OP_BIT: begin
        p[ebalu_pkg::FLAG_V] = m[6];
        p[ebalu_pkg::FLAG_Z] = ((a & m) == 8'h00);
        p[ebalu_pkg::FLAG_N] = m[7];
      end
      ebalu_pkg::OP_CMP: begin
        wide = {1'b0, r} - {1'b0, m};
        p = put_nz(p, wide[7:0]);
        p[ebalu_pkg::FLAG_C] = (r >= m);
      end
      ebalu_pkg::OP_INC: begin
        r = r + 8'd1;
        p = put_nz(p, r);
      end
      ebalu_pkg::OP_DEC: begin
        r = r - 8'd1;
        p = put_nz(p, r);
      end
      ebalu_pkg::OP_ANC: begin
        a = a & m;
        p = put_nz(p, a);
        p[ebalu_pkg::FLAG_C] = a[7];
      end
      ebalu_pkg::OP_ARR: begin
        t8 = a & m;
        a = {cin, t8[7:1]};
        p = put_nz(p, a);
        p[ebalu_pkg::FLAG_V] = a[6] ^ a[5];
        if (!dm) begin
          p[ebalu_pkg::FLAG_C] = a[6];
        end else begin
          if (int'(t8[3:0]) + int'(t8[0]) > 5) a = {a[7:4], a[3:0] + 4'd6};
          c = (int'(t8 & 8'hF0) + int'(t8 & 8'h10)) > 'h50;
          p[ebalu_pkg::FLAG_C] = c;
          if (c) a = a + 8'h60;
        end
      end
      ebalu_pkg::OP_AXS: begin
        wide = {1'b0, a & x} - {1'b0, m};
        x = wide[7:0];
        p = put_nz(p, x);
        p[ebalu_pkg::FLAG_C] = ~wide[8];
      end
      default: begin
      end
    endcase
    o.acc = a;
    o.x = x;
    o.r = r;
    o.status = p;
    return o;
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  task automatic queue_req(logic [3:0] op, logic [7:0] a, logic [7:0] x, logic [7:0] r,
                           logic [7:0] m, logic [7:0] p);
    alu_req_t q;
    q.op = op;
    q.a = a;
    q.x = x;
    q.r = r;
    q.m = m;
    q.p = p;
    pending_reqs.push_back(q);
  endtask

  function automatic logic [7:0] rand_bcd();
    return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
  endfunction

  // driver: bursts with random gaps, one forced drain partway through
  always @(posedge clk) begin
    alu_req_t q;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        q.op = s_tuser;
        q.a = s_tdata[7:0];
        q.x = s_tdata[15:8];
        q.r = s_tdata[23:16];
        q.m = s_tdata[31:24];
        q.p = s_tdata[39:32];
        expected_results.push_back(alu_predict(q));
        op_hits[q.op]++;
        if (q.p[ebalu_pkg::FLAG_D]) decimal_items++;
        items_accepted++;
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (items_accepted == DRAIN_POINT && expected_results.size() != 0) begin
          s_tvalid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          q = pending_reqs.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= q.op;
          s_tdata <= {q.p, q.m, q.r, q.x, q.a};
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks results, stalls on a mode that is redrawn at random when stall_phase wraps
  always @(posedge clk) begin
    alu_result_t e;
    logic ready_next;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result with none expected, data %h", m_tdata));
        end else begin
          e = expected_results.pop_front();
          results_checked++;
          if (m_tdata[7:0] !== e.acc)
            report_mismatch($sformatf("acc_out %h, want %h", m_tdata[7:0], e.acc));
          if (m_tdata[15:8] !== e.x)
            report_mismatch($sformatf("x_out %h, want %h", m_tdata[15:8], e.x));
          if (m_tdata[23:16] !== e.r)
            report_mismatch($sformatf("reg_out %h, want %h", m_tdata[23:16], e.r));
          if (m_tdata[31:24] !== e.status)
            report_mismatch($sformatf("status_out %h, want %h", m_tdata[31:24], e.status));
        end
      end
      if (stall_phase == 0) stall_mode = $urandom_range(0, 3);
      stall_phase = (stall_phase + 1) % 48;
      case (stall_mode)
        0: ready_next = 1'b1;
        1: ready_next = 1'($urandom_range(0, 1));
        2: ready_next = (stall_phase % 4) == 0;
        default: ready_next = (stall_phase % 16) == 5;
      endcase
      m_tready <= ready_next;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout: %0d results still expected", expected_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    logic [3:0] op;
    logic [7:0] a, m, p;

    // directed items
    queue_req(ebalu_pkg::OP_ADC, 8'h7F, 8'h00, 8'h00, 8'h01, 8'h00);  // signed overflow
    queue_req(ebalu_pkg::OP_ADC, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);  // all ones, decimal
    queue_req(ebalu_pkg::OP_ADC, 8'hFF, 8'h00, 8'h00, 8'h01, 8'h00);  // carry out, zero
    queue_req(ebalu_pkg::OP_ADC, 8'h99, 8'h00, 8'h00, 8'h01, 8'h08);  // bcd wrap to 00
    queue_req(ebalu_pkg::OP_ADC, 8'h58, 8'h00, 8'h00, 8'h46, 8'h09);  // bcd carry chain
    queue_req(ebalu_pkg::OP_ADC, 8'h00, 8'h00, 8'h00, 8'h00, 8'h08);  // bcd zero
    queue_req(ebalu_pkg::OP_SBC, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01);  // borrow
    queue_req(ebalu_pkg::OP_SBC, 8'h80, 8'h00, 8'h00, 8'h01, 8'h01);  // signed overflow
    queue_req(ebalu_pkg::OP_SBC, 8'h00, 8'h00, 8'h00, 8'h01, 8'h09);  // bcd underflow
    queue_req(ebalu_pkg::OP_SBC, 8'h46, 8'h00, 8'h00, 8'h12, 8'h08);  // bcd, borrow in
    queue_req(ebalu_pkg::OP_AND, 8'hF0, 8'h00, 8'h00, 8'h0F, 8'h00);
    queue_req(ebalu_pkg::OP_ORA, 8'h80, 8'h00, 8'h00, 8'h01, 8'hFF);
    queue_req(ebalu_pkg::OP_EOR, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00);
    queue_req(ebalu_pkg::OP_BIT, 8'h00, 8'h00, 8'h00, 8'hC0, 8'h00);
    queue_req(ebalu_pkg::OP_CMP, 8'h00, 8'h00, 8'h40, 8'h40, 8'h00);  // equal
    queue_req(ebalu_pkg::OP_CMP, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF);  // less
    queue_req(ebalu_pkg::OP_INC, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00);  // wrap to zero
    queue_req(ebalu_pkg::OP_DEC, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);  // wrap to ff
    queue_req(ebalu_pkg::OP_ANC, 8'hFF, 8'h00, 8'h00, 8'h80, 8'h00);
    queue_req(ebalu_pkg::OP_ARR, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h01);  // binary, carry in
    queue_req(ebalu_pkg::OP_ARR, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h08);  // decimal, both fixes
    queue_req(ebalu_pkg::OP_ARR, 8'h05, 8'h00, 8'h00, 8'h05, 8'h09);  // decimal, low fix
    queue_req(ebalu_pkg::OP_AXS, 8'hFF, 8'h0F, 8'h00, 8'h10, 8'h40);  // borrow, V kept
    queue_req(OP_SPARE_LO, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A);
    queue_req(OP_SPARE_HI, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00);

    // random items; decimal adds and subtracts mostly use valid bcd operands
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        op = 4'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      end else begin
        op = 4'($urandom_range(ebalu_pkg::OP_ADC, ebalu_pkg::OP_AXS));
      end
      a = 8'($urandom);
      m = 8'($urandom);
      p = 8'($urandom);
      if ((op == ebalu_pkg::OP_ADC || op == ebalu_pkg::OP_SBC)
          && p[ebalu_pkg::FLAG_D] && $urandom_range(0, 9) < 7) begin
        a = rand_bcd();
        m = rand_bcd();
      end
      queue_req(op, a, 8'($urandom), 8'($urandom), m, p);
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || s_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("checked %0d results from %0d items, %0d with decimal mode set",
             results_checked, items_accepted, decimal_items);
    $display("op codes 0-15 hit: %p", op_hits);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
